[rtl/fccm_pkg.sv]
// ----------------------------------------------------------------------------
// fccm_pkg
// Shared types and constants of the false-color colormap unit.
// ----------------------------------------------------------------------------
package fccm_pkg;

    localparam int VALUE_W   = 32;
    localparam int FRAC_BITS = 16;
    // Signed width that holds 4v - 3d without overflow.
    localparam int EW        = VALUE_W + 4;
    // Unsigned width of a nonnegative numerator.
    localparam int NW        = EW - 1;
    localparam int KW        = 16;
    // Divisor is the span shifted left by up to two places.
    localparam int DW        = VALUE_W + 2;
    localparam int QW        = 16;
    localparam int PW        = NW + KW;
    localparam int RW        = 8;

    localparam logic [VALUE_W-1:0] RANGE_HIGH_RST = VALUE_W'(1) << FRAC_BITS;

    localparam logic [KW-1:0] K_SQRT = KW'(65025);

    typedef enum logic [2:0] {
        MODE_DEFAULT = 3'd0,
        MODE_GRAY    = 3'd1,
        MODE_JET     = 3'd2,
        MODE_HOT     = 3'd3,
        MODE_COLD    = 3'd4,
        MODE_XY      = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        CFG_MAP_MODE   = 2'd0,
        CFG_RANGE_LOW  = 2'd1,
        CFG_RANGE_HIGH = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_ZERO = 2'd0,
        KIND_FULL = 2'd1,
        KIND_DIV  = 2'd2,
        KIND_SQRT = 2'd3
    } t_kind;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sample_main;
        logic signed [VALUE_W-1:0] sample_x;
    } t_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_out;

    // One channel's job for a divider lane: floor(n * k / (d << sh)).
    typedef struct packed {
        t_kind          kind;
        logic [NW-1:0]  n;
        logic [KW-1:0]  k;
        logic [1:0]     sh;
    } t_chan;

    function automatic t_chan mk_chan(t_kind kind, logic signed [EW-1:0] n,
                                      logic [KW-1:0] k, logic [1:0] sh);
        t_chan c;
        c.kind = kind;
        c.n    = n[NW-1:0];
        c.k    = k;
        c.sh   = sh;
        return c;
    endfunction

endpackage

[rtl/false_color_colormap_unit.sv]
// ----------------------------------------------------------------------------
// false_color_colormap_unit
// Maps one signed Q16.16 sample pair per request to an RGB pixel through a
// selectable false-color map.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; a stall on the output freezes the pipe.
// Each channel runs its own lane: multiply, 16 restoring divide steps and
// 8 square root steps, one per stage, which sets the depth.
// Reset clears the valid bits and loads the map registers with the default
// map over the range 0.0 to 1.0.
module false_color_colormap_unit import fccm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  t_in                i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output t_out               o_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [VALUE_W-1:0] i_cfg_data
);

    // Two front stages plus the lane depth: entry, product, overflow check
    // with the divide steps, root entry with the root steps, and the output.
    localparam int LAT = 2 + 2 + (QW + 1) + (RW + 1) + 1;

    logic [2:0]                r_mode;
    logic signed [VALUE_W-1:0] r_low;
    logic signed [VALUE_W-1:0] r_high;

    logic                      r_vld [0:LAT-1];
    logic                      en;

    logic signed [VALUE_W-1:0] r_s;
    logic signed [VALUE_W-1:0] r_sx;
    logic signed [EW-1:0]      r_v;
    logic signed [EW-1:0]      r_vx;
    logic signed [EW-1:0]      r_d;

    t_chan                     ch_r, ch_g, ch_b;
    logic [7:0]                val_r, val_g, val_b;

    // The whole pipe moves whenever the output register is free or taken,
    // so nothing is dropped or repeated under stall.
    assign en          = !r_vld[LAT-1] || !i_stall;
    assign o_stall     = !en;
    assign o_valid     = r_vld[LAT-1];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_DEFAULT;
            r_low  <= '0;
            r_high <= RANGE_HIGH_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAP_MODE:   r_mode <= i_cfg_data[2:0];
                CFG_RANGE_LOW:  r_low  <= i_cfg_data;
                CFG_RANGE_HIGH: r_high <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < LAT; j++) r_vld[j] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int j = 1; j < LAT; j++) r_vld[j] <= r_vld[j-1];
        end
    end

    // Front stages: capture the sample, then place it against the range.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s  <= i_data.sample_main;
            r_sx <= i_data.sample_x;
            r_v  <= EW'(r_s) - EW'(r_low);
            r_vx <= EW'(r_sx) - EW'(r_low);
            r_d  <= EW'(r_high) - EW'(r_low);
        end
    end

    // Region decode: each channel becomes a constant, a scaled quotient or
    // a scaled square root of a quotient.
    always_comb begin
        logic signed [EW-1:0] v2, v4, d3;
        logic                 pos, nonneg, c1, c2, c3, up;
        t_chan                zero;
        v2     = r_v <<< 1;
        v4     = r_v <<< 2;
        d3     = r_d + (r_d <<< 1);
        pos    = r_v > 0;
        nonneg = r_v >= 0;
        c1     = v4 > d3;
        c2     = v2 > r_d;
        c3     = v4 > r_d;
        up     = c2;
        zero   = mk_chan(KIND_ZERO, '0, '0, 2'd0);
        ch_r   = zero;
        ch_g   = zero;
        ch_b   = zero;
        if (r_d > 0) begin
            case (r_mode)
                MODE_GRAY: begin
                    if (nonneg) begin
                        ch_r = mk_chan(KIND_DIV, r_v, KW'(255), 2'd0);
                        ch_g = ch_r;
                        ch_b = ch_r;
                    end
                end
                MODE_JET: begin
                    if (c1) begin
                        ch_r = mk_chan(KIND_FULL, '0, '0, 2'd0);
                        if (r_v < r_d)
                            ch_g = mk_chan(KIND_DIV, r_d - r_v, KW'(1023), 2'd0);
                    end else if (c2) begin
                        ch_r = mk_chan(KIND_DIV, v2 - r_d, KW'(1023), 2'd1);
                        ch_g = mk_chan(KIND_FULL, '0, '0, 2'd0);
                    end else if (c3) begin
                        ch_g = mk_chan(KIND_FULL, '0, '0, 2'd0);
                        ch_b = mk_chan(KIND_DIV, r_d - v2, KW'(1023), 2'd1);
                    end else if (pos) begin
                        ch_g = mk_chan(KIND_DIV, r_v, KW'(1023), 2'd0);
                        ch_b = mk_chan(KIND_FULL, '0, '0, 2'd0);
                    end
                end
                MODE_HOT: begin
                    if (nonneg) begin
                        ch_r = up ? mk_chan(KIND_FULL, '0, '0, 2'd0)
                                  : mk_chan(KIND_DIV, r_v, KW'(511), 2'd0);
                        if (v4 < r_d)
                            ch_g = zero;
                        else if (c1)
                            ch_g = mk_chan(KIND_FULL, '0, '0, 2'd0);
                        else
                            ch_g = mk_chan(KIND_DIV, v4 - r_d, KW'(511), 2'd2);
                        if (up)
                            ch_b = mk_chan(KIND_DIV, v2 - r_d, KW'(511), 2'd1);
                    end
                end
                MODE_COLD: begin
                    if (pos) begin
                        if (up)
                            ch_r = mk_chan(KIND_DIV, v2 - r_d, KW'(511), 2'd1);
                        ch_g = up ? mk_chan(KIND_FULL, '0, '0, 2'd0)
                                  : mk_chan(KIND_DIV, r_v, KW'(511), 2'd0);
                        if (r_v < r_d)
                            ch_b = mk_chan(KIND_DIV, r_d - r_v, KW'(128), 2'd0);
                    end
                end
                MODE_XY: begin
                    if (pos)
                        ch_r = mk_chan(KIND_SQRT, r_v, K_SQRT, 2'd0);
                    if (r_vx > 0)
                        ch_g = mk_chan(KIND_SQRT, r_vx, K_SQRT, 2'd0);
                end
                default: begin
                    if (c1) begin
                        ch_r = mk_chan(KIND_FULL, '0, '0, 2'd0);
                        ch_g = ch_r;
                        ch_b = mk_chan(KIND_DIV, v4 - d3, KW'(1023), 2'd2);
                    end else if (c2) begin
                        ch_r = mk_chan(KIND_FULL, '0, '0, 2'd0);
                        ch_g = mk_chan(KIND_DIV, v2 - r_d, KW'(1023), 2'd1);
                    end else if (c3) begin
                        ch_r = mk_chan(KIND_SQRT, v4 - r_d, K_SQRT, 2'd0);
                        ch_b = mk_chan(KIND_DIV, r_d - v2, KW'(383), 2'd0);
                    end else if (pos) begin
                        ch_b = mk_chan(KIND_DIV, r_v, KW'(767), 2'd0);
                    end
                end
            endcase
        end
    end

    fccm_lane u_lane_r (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_chan  (ch_r),
        .i_span  (r_d[VALUE_W-1:0]),
        .o_value (val_r)
    );

    fccm_lane u_lane_g (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_chan  (ch_g),
        .i_span  (r_d[VALUE_W-1:0]),
        .o_value (val_g)
    );

    fccm_lane u_lane_b (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_chan  (ch_b),
        .i_span  (r_d[VALUE_W-1:0]),
        .o_value (val_b)
    );

    assign o_data.red   = val_r;
    assign o_data.green = val_g;
    assign o_data.blue  = val_b;

endmodule

[rtl/fccm_lane.sv]
// ----------------------------------------------------------------------------
// fccm_lane
// Pipelined multiply, restoring divide and square root for one channel.
// ----------------------------------------------------------------------------
module fccm_lane import fccm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_en,
    input  t_chan               i_chan,
    input  logic [VALUE_W-1:0]  i_span,
    output logic [7:0]          o_value
);

    // Entry stage.
    t_kind          r_kind0;
    logic [NW-1:0]  r_n0;
    logic [KW-1:0]  r_k0;
    logic [DW-1:0]  r_den0;
    // Product stage.
    t_kind          r_kind1;
    logic [PW-1:0]  r_prod1;
    logic [DW-1:0]  r_den1;
    // Divide stages.
    t_kind          r_kind  [0:QW];
    logic [PW-1:0]  r_rem   [0:QW];
    logic [QW-1:0]  r_quo   [0:QW];
    logic [DW-1:0]  r_den   [0:QW];
    logic           r_ovf   [0:QW];
    logic [PW-1:0]  n_rem   [1:QW];
    logic [QW-1:0]  n_quo   [1:QW];
    // Square root stages.
    t_kind          r_skind [0:RW];
    logic [QW-1:0]  r_x     [0:RW];
    logic [RW-1:0]  r_root  [0:RW];
    logic [RW-1:0]  n_root  [1:RW];
    logic [7:0]     r_value;
    logic [7:0]     n_value;

    always_comb begin
        for (int j = 0; j < QW; j++) begin
            logic [PW-1:0] dsh;
            dsh = PW'(r_den[j]) << (QW - 1 - j);
            if (r_rem[j] >= dsh) begin
                n_rem[j+1] = r_rem[j] - dsh;
                n_quo[j+1] = r_quo[j] | (QW'(1) << (QW - 1 - j));
            end else begin
                n_rem[j+1] = r_rem[j];
                n_quo[j+1] = r_quo[j];
            end
        end
        for (int j = 0; j < RW; j++) begin
            logic [RW-1:0]   t;
            logic [2*RW-1:0] sq;
            t  = r_root[j] | (RW'(1) << (RW - 1 - j));
            sq = t * t;
            n_root[j+1] = (sq <= r_x[j]) ? t : r_root[j];
        end
        case (r_skind[RW])
            KIND_ZERO: n_value = 8'd0;
            KIND_FULL: n_value = 8'd255;
            KIND_DIV:  n_value = (r_x[RW] > QW'(255)) ? 8'd255 : r_x[RW][7:0];
            KIND_SQRT: n_value = r_root[RW];
            default:   n_value = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_kind0 <= i_chan.kind;
            r_n0    <= i_chan.n;
            r_k0    <= i_chan.k;
            r_den0  <= DW'(i_span) << i_chan.sh;

            r_kind1 <= r_kind0;
            r_prod1 <= PW'(r_n0) * PW'(r_k0);
            r_den1  <= r_den0;

            r_kind[0] <= r_kind1;
            r_rem[0]  <= r_prod1;
            r_quo[0]  <= '0;
            r_den[0]  <= r_den1;
            r_ovf[0]  <= r_prod1 >= (PW'(r_den1) << QW);
            for (int j = 1; j <= QW; j++) begin
                r_kind[j] <= r_kind[j-1];
                r_rem[j]  <= n_rem[j];
                r_quo[j]  <= n_quo[j];
                r_den[j]  <= r_den[j-1];
                r_ovf[j]  <= r_ovf[j-1];
            end

            r_skind[0] <= r_kind[QW];
            r_x[0]     <= r_ovf[QW] ? {QW{1'b1}} : r_quo[QW];
            r_root[0]  <= '0;
            for (int j = 1; j <= RW; j++) begin
                r_skind[j] <= r_skind[j-1];
                r_x[j]     <= r_x[j-1];
                r_root[j]  <= n_root[j];
            end

            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

[tb/sv/tb_false_color_colormap_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_false_color_colormap_unit
// Self-checking bench for the false-color colormap unit. Requests carry one
// sample pair; an internal pixel predictor computes the expected RGB value
// from the current map registers, and a monitor compares every accepted
// pixel in order against the queue of predicted pixels.
// ----------------------------------------------------------------------------
module tb_false_color_colormap_unit;
    import fccm_pkg::*;

    localparam longint LIMIT_CYCLES = 400000;
    localparam int     LATENCY      = 31;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_stall;
    t_in    i_data;
    logic   o_valid;
    logic   i_stall;
    t_out   o_data;
    logic   i_cfg_valid;
    logic   o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [VALUE_W-1:0] i_cfg_data;

    false_color_colormap_unit DUT (.*);

    // Shadow copy of the map registers, updated whenever a write lands.
    logic [2:0]     cur_mode;
    longint         cur_low;
    longint         cur_high;

    t_out   pixel_q[$];
    int     mismatches = 0;
    longint cycle = 0;
    bit     calm;       // when set, neither side idles at random
    bit     hold_out;   // forces a long output stall

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // floor(n*k/d), capped at 64'hFFFFF; clip8 and root_scaled narrow it to the block's range.
    function automatic longint scale_div(longint n, longint k, longint d);
        longint q;
        q = n / d;
        if (q > 64'hFFFF) return 64'hFFFFF;
        q = q * k + ((n % d) * k) / d;
        return q > 64'hFFFFF ? 64'hFFFFF : q;
    endfunction

    function automatic logic [7:0] clip8(longint x);
        return x > 255 ? 8'd255 : x[7:0];
    endfunction

    // 255*sqrt(n/d) truncated.
    function automatic logic [7:0] root_scaled(longint n, longint d);
        longint x, r;
        x = scale_div(n, 65025, d);
        if (x > 65535) x = 65535;
        r = 0;
        while ((r + 1) * (r + 1) <= x) r++;
        return r[7:0];
    endfunction

    function automatic t_out predict_pixel(t_in s);
        t_out   p;
        longint d, v, vx;
        d  = cur_high - cur_low;
        v  = longint'(s.sample_main) - cur_low;
        vx = longint'(s.sample_x) - cur_low;
        p  = '0;
        if (d > 0) begin
            case (cur_mode)
                MODE_GRAY: begin
                    if (v >= 0) begin
                        p.red   = clip8(scale_div(v, 255, d));
                        p.green = p.red;
                        p.blue  = p.red;
                    end
                end
                MODE_JET: begin
                    if (4 * v > 3 * d) begin
                        p.red   = 8'd255;
                        p.green = v >= d ? 8'd0 : clip8(scale_div(d - v, 1023, d));
                    end else if (2 * v > d) begin
                        p.red   = clip8(scale_div(2 * v - d, 1023, 2 * d));
                        p.green = 8'd255;
                    end else if (4 * v > d) begin
                        p.green = 8'd255;
                        p.blue  = clip8(scale_div(d - 2 * v, 1023, 2 * d));
                    end else if (v > 0) begin
                        p.green = clip8(scale_div(v, 1023, d));
                        p.blue  = 8'd255;
                    end
                end
                MODE_HOT: begin
                    if (v >= 0) begin
                        p.red = 2 * v > d ? 8'd255 : clip8(scale_div(v, 511, d));
                        if (4 * v < d) p.green = 8'd0;
                        else if (4 * v > 3 * d) p.green = 8'd255;
                        else p.green = clip8(scale_div(4 * v - d, 511, 4 * d));
                        p.blue = 2 * v > d ? clip8(scale_div(2 * v - d, 511, 2 * d)) : 8'd0;
                    end
                end
                MODE_COLD: begin
                    if (v > 0) begin
                        p.red   = 2 * v > d ? clip8(scale_div(2 * v - d, 511, 2 * d)) : 8'd0;
                        p.green = 2 * v > d ? 8'd255 : clip8(scale_div(v, 511, d));
                        p.blue  = v >= d ? 8'd0 : clip8(scale_div(d - v, 128, d));
                    end
                end
                MODE_XY: begin
                    if (v > 0) p.red = root_scaled(v, d);
                    if (vx > 0) p.green = root_scaled(vx, d);
                end
                default: begin
                    // Default map; the unused mode codes fall here too.
                    if (4 * v > 3 * d) begin
                        p.red   = 8'd255;
                        p.green = 8'd255;
                        p.blue  = clip8(scale_div(4 * v - 3 * d, 1023, 4 * d));
                    end else if (2 * v > d) begin
                        p.red   = 8'd255;
                        p.green = clip8(scale_div(2 * v - d, 1023, 2 * d));
                    end else if (4 * v > d) begin
                        p.red  = root_scaled(4 * v - d, d);
                        p.blue = clip8(scale_div(d - 2 * v, 383, d));
                    end else if (v > 0) begin
                        p.blue = clip8(scale_div(v, 767, d));
                    end
                end
            endcase
        end
        return p;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle, what, got, want);
        mismatches++;
    endtask

    // Output side: random stalls, plus the forced long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= hold_out || (!calm && $urandom_range(99) < 29);
        end
    end

    // Compares each accepted pixel with the oldest prediction.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pixel_q.size() == 0) begin
                report_mismatch("unexpected pixel", o_data, 0);
            end else begin
                want = pixel_q.pop_front();
                if (o_data.red !== want.red) report_mismatch("red", o_data.red, want.red);
                if (o_data.green !== want.green)
                    report_mismatch("green", o_data.green, want.green);
                if (o_data.blue !== want.blue)
                    report_mismatch("blue", o_data.blue, want.blue);
            end
        end
    end

    // Sends one request and predicts its pixel once it is taken.
    task automatic send_sample(logic [31:0] main, logic [31:0] x);
        t_in s;
        while (!calm && $urandom_range(99) < 29) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        s.sample_main = main;
        s.sample_x    = x;
        i_valid <= 1'b1;
        i_data  <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pixel_q.push_back(predict_pixel(s));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    // Writes one map register; only called while the pipe is empty.
    task automatic write_reg(t_cfg_idx idx, logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_MAP_MODE:  cur_mode = value[2:0];
            CFG_RANGE_LOW: cur_low  = longint'(signed'(value));
            default:       cur_high = longint'(signed'(value));
        endcase
    endtask

    function automatic logic [31:0] rand_sample();
        longint span;
        span = cur_high - cur_low;
        case ($urandom_range(5))
            0: return $urandom;
            1: return {$urandom_range(1) ? 1'b1 : 1'b0, 31'h0} | $urandom_range(3);
            default: begin
                // Mostly within or near the configured range.
                if (span > 0 && span < 64'h1_0000_0000)
                    return 32'(cur_low - span / 8
                               + longint'($urandom) % (span + span / 4 + 1));
                return $urandom;
            end
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] edges[7];
        edges = '{32'h0, 32'h4000, 32'h8000, 32'hC000, 32'h10000,
                  32'h8000_0000, 32'h7FFF_FFFF};
        for (int m = 0; m < 8; m++) begin
            write_reg(CFG_MAP_MODE, 32'(m));
            foreach (edges[e]) send_sample(edges[e], edges[6 - e]);
            drain();
        end
    endtask

    task automatic test_extreme_ranges();
        // Full span, inverted span and zero span.
        write_reg(CFG_RANGE_LOW, 32'h8000_0000);
        write_reg(CFG_RANGE_HIGH, 32'h7FFF_FFFF);
        for (int m = 0; m < 6; m++) begin
            write_reg(CFG_MAP_MODE, 32'(m));
            repeat (8) send_sample($urandom, $urandom);
            send_sample(32'h7FFF_FFFF, 32'h8000_0000);
            drain();
        end
        write_reg(CFG_RANGE_LOW, 32'h10000);
        write_reg(CFG_RANGE_HIGH, 32'h10000);
        repeat (4) send_sample($urandom, $urandom);
        drain();
        write_reg(CFG_RANGE_HIGH, 32'hFFFF_0000);
        repeat (4) send_sample($urandom, $urandom);
        drain();
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 10; phase++) begin
            write_reg(CFG_MAP_MODE, 32'($urandom_range(7)));
            write_reg(CFG_RANGE_LOW, $urandom_range(1) ? 32'($urandom) >>> $urandom_range(31)
                                                      : -32'($urandom_range(70000)));
            write_reg(CFG_RANGE_HIGH,
                      32'(cur_low + 1 + $urandom_range(1 << $urandom_range(30))));
            calm = (phase == 4);
            repeat (24) send_sample(rand_sample(), rand_sample());
            calm = 1'b0;
            drain();
        end
    endtask

    task automatic test_backpressure();
        write_reg(CFG_MAP_MODE, 32'(MODE_JET));
        write_reg(CFG_RANGE_LOW, 32'h0);
        write_reg(CFG_RANGE_HIGH, 32'h10000);
        hold_out = 1'b1;
        fork
            begin
                repeat (120) @(posedge i_clk);
                hold_out = 1'b0;
            end
            repeat (60) send_sample(rand_sample(), rand_sample());
        join
        drain();
    endtask

    initial begin
        calm        = 1'b0;
        hold_out    = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MAP_MODE;
        i_cfg_data  = '0;
        cur_mode    = MODE_DEFAULT;
        cur_low     = 0;
        cur_high    = longint'(RANGE_HIGH_RST);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_extreme_ranges();
        test_random();
        test_backpressure();

        if (mismatches == 0 && pixel_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

[false_color_colormap_unit.f]
rtl/fccm_pkg.sv
rtl/fccm_lane.sv
rtl/false_color_colormap_unit.sv
tb/sv/tb_false_color_colormap_unit.sv
